### src/sdtq_pkg.sv
// Package for the sorted deadline timer queue.
// Holds sizes, mode and result codes, controller types and tag helpers.
// No dependencies.
package sdtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TAG_WIDTH   = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int TAG_FIELD_W = 16;
   localparam int DEST_W      = 8;
   localparam int TIME_W      = 32;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_SET   = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] KIND_FIRED    = 2'd0;
   localparam logic [1:0] KIND_SET_OK   = 2'd1;
   localparam logic [1:0] KIND_SET_FULL = 2'd2;
   localparam logic [1:0] KIND_DISCARD  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SET,
      ST_DRAIN,
      ST_CLEAR
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       inc_elapsed;
      logic       insert;
      logic       pop;
      logic       emit;
      logic       emit_from_set;
      logic [1:0] emit_kind;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic count_zero;
      logic count_one;
      logic count_full;
      logic head_due;
      logic next_due;
   } status_type;

   function automatic logic [TAG_WIDTH-1:0] tag_store(input logic [TAG_FIELD_W-1:0] v);
      logic [TAG_WIDTH-1:0] r;
      r = '0;
      for (int i = 0; i < TAG_WIDTH; i++) begin
         if (i < TAG_FIELD_W) begin
            r[i] = v[i];
         end
      end
      return r;
   endfunction

   function automatic logic [TAG_FIELD_W-1:0] tag_field(input logic [TAG_WIDTH-1:0] v);
      logic [TAG_FIELD_W-1:0] r;
      r = '0;
      for (int i = 0; i < TAG_FIELD_W; i++) begin
         if (i < TAG_WIDTH) begin
            r[i] = v[i];
         end
      end
      return r;
   endfunction

endpackage

### src/sdtq_req_if.sv
// Request channel of the timer queue: valid/ready plus one set/tick/clear item.
// Depends on sdtq_pkg.
interface sdtq_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      mode;
   logic [sdtq_pkg::TIME_W-1:0]     timeout;
   logic [sdtq_pkg::TAG_FIELD_W-1:0] message_tag;
   logic [sdtq_pkg::DEST_W-1:0]     destination;

   modport source (output valid, mode, timeout, message_tag, destination, input ready);
   modport sink   (input valid, mode, timeout, message_tag, destination, output ready);
endinterface

### src/sdtq_rsp_if.sv
// Response channel of the timer queue: valid/ready plus one result beat.
// Depends on sdtq_pkg.
interface sdtq_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      kind;
   logic [sdtq_pkg::TAG_FIELD_W-1:0] message_tag_res;
   logic [sdtq_pkg::DEST_W-1:0]     destination_res;
   logic                            last;

   modport source (output valid, kind, message_tag_res, destination_res, last, input ready);
   modport sink   (input valid, kind, message_tag_res, destination_res, last, output ready);
endinterface

### src/sdtq_ctrl.sv
// Controller FSM of the timer queue: sequences set, tick drain and clear.
// Depends on sdtq_pkg; drives the datapath by cmd_type, reads status_type.
module sdtq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_mode,
   output logic                 req_ready,
   input  sdtq_pkg::status_type status,
   output sdtq_pkg::cmd_type    cmd
);

   sdtq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdtq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdtq_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_mode)
                  sdtq_pkg::MODE_TICK:  state_in = sdtq_pkg::ST_DRAIN;
                  sdtq_pkg::MODE_SET:   state_in = sdtq_pkg::ST_SET;
                  sdtq_pkg::MODE_CLEAR: state_in = sdtq_pkg::ST_CLEAR;
                  default:              state_in = sdtq_pkg::ST_IDLE;
               endcase
            end
         end
         sdtq_pkg::ST_SET: begin
            if (status.out_free) begin
               state_in = sdtq_pkg::ST_IDLE;
            end
         end
         sdtq_pkg::ST_DRAIN: begin
            if (!status.head_due) begin
               state_in = sdtq_pkg::ST_IDLE;
            end else if (status.out_free && !status.next_due) begin
               state_in = sdtq_pkg::ST_IDLE;
            end
         end
         sdtq_pkg::ST_CLEAR: begin
            if (status.count_zero) begin
               state_in = sdtq_pkg::ST_IDLE;
            end else if (status.out_free && status.count_one) begin
               state_in = sdtq_pkg::ST_IDLE;
            end
         end
         default: state_in = sdtq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         sdtq_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.capture     = req_valid;
            cmd.inc_elapsed = req_valid && (req_mode == sdtq_pkg::MODE_TICK);
         end
         sdtq_pkg::ST_SET: begin
            if (status.out_free) begin
               cmd.emit          = 1'b1;
               cmd.emit_from_set = 1'b1;
               cmd.emit_last     = 1'b1;
               cmd.insert        = !status.count_full;
               cmd.emit_kind     = status.count_full ? sdtq_pkg::KIND_SET_FULL
                                                     : sdtq_pkg::KIND_SET_OK;
            end
         end
         sdtq_pkg::ST_DRAIN: begin
            if (status.head_due && status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.pop       = 1'b1;
               cmd.emit_kind = sdtq_pkg::KIND_FIRED;
               cmd.emit_last = !status.next_due;
            end
         end
         sdtq_pkg::ST_CLEAR: begin
            if (!status.count_zero && status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.pop       = 1'b1;
               cmd.emit_kind = sdtq_pkg::KIND_DISCARD;
               cmd.emit_last = status.count_one;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

### src/sdtq_dp.sv
// Datapath of the timer queue: sorted shift cells, elapsed counter, output register.
// Depends on sdtq_pkg; controlled by sdtq_ctrl through cmd_type.
module sdtq_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sdtq_pkg::TIME_W-1:0]       req_timeout,
   input  logic [sdtq_pkg::TAG_FIELD_W-1:0]  req_message_tag,
   input  logic [sdtq_pkg::DEST_W-1:0]       req_destination,
   input  sdtq_pkg::cmd_type                 cmd,
   output sdtq_pkg::status_type              status,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_kind,
   output logic [sdtq_pkg::TAG_FIELD_W-1:0]  rsp_message_tag_res,
   output logic [sdtq_pkg::DEST_W-1:0]       rsp_destination_res,
   output logic                              rsp_last
);

   localparam int N = sdtq_pkg::QUEUE_DEPTH;

   logic [sdtq_pkg::TIME_W-1:0]      elapsed_ff, elapsed_in;
   logic [sdtq_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [sdtq_pkg::TIME_W-1:0]      dl_ff  [N];
   logic [sdtq_pkg::TIME_W-1:0]      dl_in  [N];
   logic [sdtq_pkg::TAG_WIDTH-1:0]   tag_ff [N];
   logic [sdtq_pkg::TAG_WIDTH-1:0]   tag_in [N];
   logic [sdtq_pkg::DEST_W-1:0]      dst_ff [N];
   logic [sdtq_pkg::DEST_W-1:0]      dst_in [N];
   logic [N-1:0]                     le;

   logic [sdtq_pkg::TIME_W-1:0]      new_dl_ff;
   logic [sdtq_pkg::TAG_WIDTH-1:0]   new_tag_ff;
   logic [sdtq_pkg::DEST_W-1:0]      new_dst_ff;

   logic                             out_valid_ff, out_valid_in;
   logic [1:0]                       out_kind_ff;
   logic [sdtq_pkg::TAG_FIELD_W-1:0] out_tag_ff;
   logic [sdtq_pkg::DEST_W-1:0]      out_dst_ff;
   logic                             out_last_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         elapsed_ff   <= elapsed_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      elapsed_in = cmd.inc_elapsed ? elapsed_ff + 1'b1 : elapsed_ff;
      count_in   = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // cells at or past count hold stale data; the prefix test keeps them out
   always_comb begin
      for (int i = 0; i < N; i++) begin
         le[i] = (sdtq_pkg::CNT_W'(i) < count_ff) && (dl_ff[i] <= new_dl_ff);
      end
      for (int i = 0; i < N; i++) begin
         dl_in[i]  = dl_ff[i];
         tag_in[i] = tag_ff[i];
         dst_in[i] = dst_ff[i];
         if (cmd.insert && !le[i]) begin
            if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
               dl_in[i]  = new_dl_ff;
               tag_in[i] = new_tag_ff;
               dst_in[i] = new_dst_ff;
            end else begin
               dl_in[i]  = dl_ff[(i == 0) ? 0 : i - 1];
               tag_in[i] = tag_ff[(i == 0) ? 0 : i - 1];
               dst_in[i] = dst_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (cmd.pop && i < N - 1) begin
            dl_in[i]  = dl_ff[(i < N - 1) ? i + 1 : i];
            tag_in[i] = tag_ff[(i < N - 1) ? i + 1 : i];
            dst_in[i] = dst_ff[(i < N - 1) ? i + 1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         dl_ff[i]  <= dl_in[i];
         tag_ff[i] <= tag_in[i];
         dst_ff[i] <= dst_in[i];
      end
      if (cmd.capture) begin
         new_dl_ff  <= elapsed_ff + req_timeout;
         new_tag_ff <= sdtq_pkg::tag_store(req_message_tag);
         new_dst_ff <= req_destination;
      end
      if (cmd.emit) begin
         out_kind_ff <= cmd.emit_kind;
         out_last_ff <= cmd.emit_last;
         if (cmd.emit_from_set) begin
            out_tag_ff <= sdtq_pkg::tag_field(new_tag_ff);
            out_dst_ff <= new_dst_ff;
         end else begin
            out_tag_ff <= sdtq_pkg::tag_field(tag_ff[0]);
            out_dst_ff <= dst_ff[0];
         end
      end
   end

   always_comb begin
      status.out_free   = !out_valid_ff || rsp_ready;
      status.count_zero = (count_ff == '0);
      status.count_one  = (count_ff == sdtq_pkg::CNT_W'(1));
      status.count_full = (count_ff == sdtq_pkg::CNT_W'(N));
      status.head_due   = (count_ff != '0) && (dl_ff[0] <= elapsed_ff);
      status.next_due   = (count_ff > sdtq_pkg::CNT_W'(1)) && (dl_ff[1] <= elapsed_ff);
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_kind            = out_kind_ff;
   assign rsp_message_tag_res = out_tag_ff;
   assign rsp_destination_res = out_dst_ff;
   assign rsp_last            = out_last_ff;

endmodule

### src/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue, top level: controller plus shift-cell datapath.
// The first result beat is registered in the set, drain or clear state that
// follows the taken item, once the single output register is free. A new item is
// taken only when idle; tick and clear pop one head per cycle while it is free.
// Reset (synchronous, active high) zeroes elapsed time and empties the queue.
// Depends on sdtq_pkg, sdtq_req_if, sdtq_rsp_if, sdtq_ctrl, sdtq_dp.
module sorted_deadline_timer_queue (
   input  logic       clock,
   input  logic       reset,
   sdtq_req_if.sink   req_if,
   sdtq_rsp_if.source rsp_if
);

   sdtq_pkg::cmd_type    cmd;
   sdtq_pkg::status_type status;

   sdtq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_mode  (req_if.mode),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   sdtq_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_timeout         (req_if.timeout),
      .req_message_tag     (req_if.message_tag),
      .req_destination     (req_if.destination),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_if.ready),
      .rsp_valid           (rsp_if.valid),
      .rsp_kind            (rsp_if.kind),
      .rsp_message_tag_res (rsp_if.message_tag_res),
      .rsp_destination_res (rsp_if.destination_res),
      .rsp_last            (rsp_if.last)
   );

endmodule

### src/sdtq_checker.sv
// Port-level checks for the timer queue, bound to the top level.
// Depends on sdtq_pkg and sorted_deadline_timer_queue.
module sdtq_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [1:0]                       rsp_kind,
   input logic [sdtq_pkg::TAG_FIELD_W-1:0] rsp_message_tag_res,
   input logic [sdtq_pkg::DEST_W-1:0]      rsp_destination_res,
   input logic                             rsp_last
);

   logic                       beat;
   logic [sdtq_pkg::CNT_W-1:0] pend_ff, pend_in;

   assign beat = rsp_valid && rsp_ready;

   // entries held, as seen from result beats
   always_comb begin
      pend_in = pend_ff;
      if (beat && rsp_kind == sdtq_pkg::KIND_SET_OK) begin
         pend_in = pend_ff + 1'b1;
      end else if (beat && (rsp_kind == sdtq_pkg::KIND_FIRED ||
                            rsp_kind == sdtq_pkg::KIND_DISCARD)) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      beat && (rsp_kind == sdtq_pkg::KIND_FIRED || rsp_kind == sdtq_pkg::KIND_DISCARD)
      |-> pend_ff != '0)
      else $error("entry fired or discarded from an empty queue");

   a_full_matches: assert property (@(posedge clock) disable iff (reset)
      beat && (rsp_kind == sdtq_pkg::KIND_SET_OK || rsp_kind == sdtq_pkg::KIND_SET_FULL)
      |-> ((rsp_kind == sdtq_pkg::KIND_SET_FULL) ==
           (pend_ff == sdtq_pkg::CNT_W'(sdtq_pkg::QUEUE_DEPTH))) && rsp_last)
      else $error("set result disagrees with queue occupancy");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_message_tag_res) && $stable(rsp_destination_res) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_kind            (rsp_if.kind),
   .rsp_message_tag_res (rsp_if.message_tag_res),
   .rsp_destination_res (rsp_if.destination_res),
   .rsp_last            (rsp_if.last)
);

### tb/tb_top.sv
// Self-checking bench for sorted_deadline_timer_queue: set, tick and clear items
// are checked beat by beat against a deadline-ordered queue predictor.
// Depends on sdtq_pkg, sdtq_req_if, sdtq_rsp_if and the RTL top.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [1:0]  MODE_SPARE      = 2'd3;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          SETTLE_CYCLES   = 20;
   localparam int          HOLD_OFF_CYCLES = 200;
   localparam int          MAX_REPORTS     = 10;
   localparam logic [63:0] TAG_KEEP        = (64'd1 << sdtq_pkg::TAG_WIDTH) - 64'd1;

   typedef struct packed {
      logic [1:0]                       kind;
      logic [sdtq_pkg::TAG_FIELD_W-1:0] tag;
      logic [sdtq_pkg::DEST_W-1:0]      dest;
      logic                             last;
   } beat_type;

   logic clock;
   logic reset;

   sdtq_req_if req_ch ();
   sdtq_rsp_if rsp_ch ();

   sorted_deadline_timer_queue dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // predictor state
   logic [sdtq_pkg::TIME_W-1:0]      now_ms = '0;
   logic [sdtq_pkg::TIME_W-1:0]      slot_deadline [sdtq_pkg::QUEUE_DEPTH];
   logic [sdtq_pkg::TAG_FIELD_W-1:0] slot_tag      [sdtq_pkg::QUEUE_DEPTH];
   logic [sdtq_pkg::DEST_W-1:0]      slot_dest     [sdtq_pkg::QUEUE_DEPTH];
   int                               slot_count = 0;

   beat_type owed_beats[$];

   int  mismatches    = 0;
   int  beats_checked = 0;
   int  rejects_seen  = 0;
   int  mode_hits [4] = '{0, 0, 0, 0};
   bit  gaps_on       = 1'b0;
   int  hold_len      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void owe_beat(input logic [1:0] kind,
                                    input logic [sdtq_pkg::TAG_FIELD_W-1:0] tag,
                                    input logic [sdtq_pkg::DEST_W-1:0] dest);
      beat_type b;
      b.kind = kind;
      b.tag  = tag;
      b.dest = dest;
      b.last = 1'b0;
      owed_beats.push_back(b);
   endfunction

   function automatic void predict_timer_beats(
      input logic [1:0]                       mode,
      input logic [sdtq_pkg::TIME_W-1:0]      timeout,
      input logic [sdtq_pkg::TAG_FIELD_W-1:0] tag_in,
      input logic [sdtq_pkg::DEST_W-1:0]      dest);
      int                               first;
      int                               pos;
      int                               i;
      logic [sdtq_pkg::TIME_W-1:0]      deadline;
      logic [sdtq_pkg::TAG_FIELD_W-1:0] tag;
      beat_type                         b;
      first = owed_beats.size();
      tag   = tag_in & TAG_KEEP[sdtq_pkg::TAG_FIELD_W-1:0];
      case (mode)
         sdtq_pkg::MODE_TICK: begin
            now_ms = now_ms + 1'b1;
            while (slot_count > 0 && slot_deadline[0] <= now_ms) begin
               owe_beat(sdtq_pkg::KIND_FIRED, slot_tag[0], slot_dest[0]);
               for (i = 1; i < slot_count; i++) begin
                  slot_deadline[i-1] = slot_deadline[i];
                  slot_tag[i-1]      = slot_tag[i];
                  slot_dest[i-1]     = slot_dest[i];
               end
               slot_count--;
            end
         end
         sdtq_pkg::MODE_SET: begin
            if (slot_count >= sdtq_pkg::QUEUE_DEPTH) begin
               owe_beat(sdtq_pkg::KIND_SET_FULL, tag, dest);
            end else begin
               deadline = now_ms + timeout;
               pos = 0;
               while (pos < slot_count && slot_deadline[pos] <= deadline) pos++;
               for (i = slot_count; i > pos; i--) begin
                  slot_deadline[i] = slot_deadline[i-1];
                  slot_tag[i]      = slot_tag[i-1];
                  slot_dest[i]     = slot_dest[i-1];
               end
               slot_deadline[pos] = deadline;
               slot_tag[pos]      = tag;
               slot_dest[pos]     = dest;
               slot_count++;
               owe_beat(sdtq_pkg::KIND_SET_OK, tag, dest);
            end
         end
         sdtq_pkg::MODE_CLEAR: begin
            for (i = 0; i < slot_count; i++)
               owe_beat(sdtq_pkg::KIND_DISCARD, slot_tag[i], slot_dest[i]);
            slot_count = 0;
         end
         default: ;
      endcase
      if (owed_beats.size() > first) begin
         b = owed_beats.pop_back();
         b.last = 1'b1;
         owed_beats.push_back(b);
      end
   endfunction

   function automatic logic [sdtq_pkg::TAG_FIELD_W-1:0] rand_tag();
      return sdtq_pkg::TAG_FIELD_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic [sdtq_pkg::DEST_W-1:0] rand_dest();
      return sdtq_pkg::DEST_W'($urandom_range(0, 255));
   endfunction

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_item(input logic [1:0] mode,
                            input logic [sdtq_pkg::TIME_W-1:0] timeout,
                            input logic [sdtq_pkg::TAG_FIELD_W-1:0] tag,
                            input logic [sdtq_pkg::DEST_W-1:0] dest);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.mode        <= mode;
      req_ch.timeout     <= timeout;
      req_ch.message_tag <= tag;
      req_ch.destination <= dest;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_timer_beats(mode, timeout, tag, dest);
      mode_hits[mode]++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (owed_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [sdtq_pkg::TIME_W-1:0] pick_timeout();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 6);
      if (r < 70) return $urandom_range(7, 60);
      if (r < 80) return $urandom;
      if (r < 92) return 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
      return 32'hFFFF_FFFF;
   endfunction

   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 52)
         send_item(sdtq_pkg::MODE_TICK, $urandom, rand_tag(), rand_dest());
      else if (r < 88)
         send_item(sdtq_pkg::MODE_SET, pick_timeout(), rand_tag(), rand_dest());
      else if (r < 95)
         send_item(sdtq_pkg::MODE_CLEAR, $urandom, rand_tag(), rand_dest());
      else
         send_item(MODE_SPARE, $urandom, rand_tag(), rand_dest());
   endtask

   task automatic test_empty_queue();
      send_item(sdtq_pkg::MODE_TICK, $urandom, rand_tag(), rand_dest());
      send_item(sdtq_pkg::MODE_CLEAR, $urandom, rand_tag(), rand_dest());
      send_item(MODE_SPARE, $urandom, rand_tag(), rand_dest());
      wait_drained();
   endtask

   // zero timeout, wrapped deadline and a tie, then a clear of a far timer
   task automatic test_expiry_order();
      send_item(sdtq_pkg::MODE_SET, 32'd0, 16'h0000, 8'h00);
      send_item(sdtq_pkg::MODE_SET, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      send_item(sdtq_pkg::MODE_SET, 32'd2, 16'hA5A5, 8'h5A);
      send_item(sdtq_pkg::MODE_SET, 32'd2, 16'h5A5A, 8'hA5);
      send_item(sdtq_pkg::MODE_TICK, 32'd0, 16'h0000, 8'h00);
      send_item(sdtq_pkg::MODE_TICK, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF);
      send_item(sdtq_pkg::MODE_TICK, 32'd0, 16'h0000, 8'h00);
      send_item(sdtq_pkg::MODE_SET, 32'h8000_0000, 16'h1234, 8'h42);
      send_item(sdtq_pkg::MODE_CLEAR, 32'd0, 16'h0000, 8'h00);
      wait_drained();
   endtask

   task automatic test_queue_full();
      repeat (sdtq_pkg::QUEUE_DEPTH + 1)
         send_item(sdtq_pkg::MODE_SET, 32'h4000_0000 + 32'($urandom_range(0, 8)),
                   rand_tag(), rand_dest());
      send_item(sdtq_pkg::MODE_TICK, $urandom, rand_tag(), rand_dest());
      send_item(sdtq_pkg::MODE_CLEAR, $urandom, rand_tag(), rand_dest());
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering firing timers
   task automatic test_backpressure();
      hold_len = HOLD_OFF_CYCLES;
      repeat (12) begin
         send_item(sdtq_pkg::MODE_SET, $urandom_range(0, 3), rand_tag(), rand_dest());
         send_item(sdtq_pkg::MODE_TICK, $urandom, rand_tag(), rand_dest());
      end
      wait_drained();
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_random_item();
      wait_drained();
   endtask

   // response sink: random stall bursts plus requested long hold-offs
   initial begin
      int stall;
      stall = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            stall = hold_len;
            hold_len = 0;
         end else if (stall == 0 && gaps_on && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 15);
         end
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         beats_checked++;
         if (rsp_ch.kind == sdtq_pkg::KIND_SET_FULL) rejects_seen++;
         if (owed_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t unexpected beat: kind=%0d tag=%h dest=%h last=%0b",
                        $realtime, rsp_ch.kind, rsp_ch.message_tag_res,
                        rsp_ch.destination_res, rsp_ch.last);
         end else begin
            want = owed_beats.pop_front();
            if (rsp_ch.kind != want.kind || rsp_ch.message_tag_res != want.tag ||
                rsp_ch.destination_res != want.dest || rsp_ch.last != want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t beat mismatch: exp kind=%0d tag=%h dest=%h last=%0b",
                           $realtime, want.kind, want.tag, want.dest, want.last);
                  $display("   got kind=%0d tag=%h dest=%h last=%0b", rsp_ch.kind,
                           rsp_ch.message_tag_res, rsp_ch.destination_res, rsp_ch.last);
               end
            end
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no beat for %0d cycles, %0d beats still owed", WATCHDOG_LIMIT,
               owed_beats.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.mode        = sdtq_pkg::MODE_TICK;
      req_ch.timeout     = '0;
      req_ch.message_tag = '0;
      req_ch.destination = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_queue();
      test_expiry_order();
      test_queue_full();
      test_backpressure();
      gaps_on = 1'b1;
      test_random_traffic(145);
      gaps_on = 1'b0;
      test_random_traffic(30);

      $display("Sent %0d ticks, %0d sets, %0d clears, %0d spare-mode items.",
               mode_hits[sdtq_pkg::MODE_TICK], mode_hits[sdtq_pkg::MODE_SET],
               mode_hits[sdtq_pkg::MODE_CLEAR], mode_hits[MODE_SPARE]);
      $display("Checked %0d result beats (%0d full rejects), %0d mismatches, %0d left owed.",
               beats_checked, rejects_seen, mismatches, owed_beats.size());
      if (mismatches == 0 && owed_beats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
